// ----- rtl/rdr_pkg.sv -----
// ---------------------------------------------------------------------------
// rdr_pkg: shared types and constants of the radial distortion remap
// Frame geometry, pipeline depths and the request record that travels
// along the remap pipeline.
// ---------------------------------------------------------------------------
package rdr_pkg;

    localparam int ImageWidth  = 80;
    localparam int ImageHeight = 60;
    localparam int RowBytes    = (ImageWidth + 7) / 8;
    localparam int FrameBytes  = RowBytes * ImageHeight;
    localparam int CenterX     = ImageWidth / 2;
    localparam int CenterY     = ImageHeight / 2;

    localparam int AddrW   = 10;
    localparam int RowW    = 6;
    localparam int ColW    = 7;
    localparam int DxW     = 8;
    localparam int DyW     = 7;
    localparam int SqW     = 14;
    localparam int RootW   = 36;
    localparam int SqrtN   = 17;
    localparam int DistW   = 17;
    localparam int DivN    = 16;
    localparam int ThetaW  = 17;
    localparam int ProdW   = ThetaW + 1 + DxW;

    // stage numbers of the request record
    localparam int StSqrt0 = 1;
    localparam int StDiv0  = StSqrt0 + SqrtN;
    localparam int StTheta = StDiv0 + DivN;
    localparam int StProd  = StTheta + 1;
    localparam int StCoord = StProd + 1;
    localparam int StMem   = StCoord + 1;
    localparam int NumSt   = StMem + 1;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                   valid;
        cmd_t                   cmd;
        logic [AddrW-1:0]       byte_index;
        logic [7:0]             byte_value;
        logic signed [DxW-1:0]  dx;
        logic signed [DyW-1:0]  dy;
        logic [7:0]             radius;
    } req_t;

endpackage

// ----- rtl/radial_distortion_remap.sv -----
// ---------------------------------------------------------------------------
// radial_distortion_remap: radial lens correction of a packed 1-bit frame
//
// Input stream (s_*): one request per accepted beat. tuser = 0 writes the
// frame byte byte_value at byte_index; tuser = 1 queries output pixel
// (out_row, out_col). A write gives no result; a query gives one result on
// the m_* stream: the source pixel and the source row and column it was
// taken from. Results leave in request order.
// Throughput: one request per cycle unless the receiver stalls. The request
// passes 38 register stages, the first loaded by the accepting edge: input
// register, 17 square-root steps, 16 divider steps, scale, product, clamp
// and the frame memory read. The user writes the radius register through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block does not
// enforce it. Each request carries the radius it was accepted with.
// Reset (aresetn low, synchronous) empties the pipeline and sets radius to
// 50. The frame memory is not cleared: query only bytes already written.
// When the receiver stalls, the whole pipeline holds and s_tready drops;
// writes and memory reads hold with it, so write/query order is kept.
// ---------------------------------------------------------------------------
module radial_distortion_remap
    import rdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] byte_index, [17:10] byte_value, [23:18] out_row, [30:24] out_col
    input  logic [31:0] s_tdata,
    // [0] cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pixel, [6:1] source_row, [13:7] source_col
    output logic [15:0] m_tdata
);

    logic [7:0] radius_reg;
    logic       adv;
    req_t       req_reg [NumSt];
    req_t       req_next;

    // square root pipeline: remainder and root per step
    logic [RootW-1:0] srem_reg [SqrtN];
    logic [RootW-1:0] sres_reg [SqrtN];
    // divider pipeline: partial remainder, quotient bits, distance
    logic [7:0]       drem_reg [DivN];
    logic [DivN-1:0]  dq_reg   [DivN];
    logic [DistW-1:0] dd_reg   [DivN];

    logic [ThetaW-1:0]       theta_reg;
    logic signed [ProdW-1:0] px_reg, py_reg;
    logic [ColW-1:0]         sx_reg, sx_mem_reg;
    logic [RowW-1:0]         sy_reg, sy_mem_reg;
    logic [7:0]              rd_reg;

    logic [7:0] frame_mem [FrameBytes];

    logic [SqW-1:0] sq_next;

    // Advance the whole pipeline unless a result waits at the output.
    assign adv      = !req_reg[NumSt-1].valid || (req_reg[NumSt-1].cmd != CMD_QUERY)
                      || m_tready;
    assign s_tready = adv;
    assign m_tvalid = req_reg[NumSt-1].valid && (req_reg[NumSt-1].cmd == CMD_QUERY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 8'd50;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    // Form the request record, with centered offsets of the query pixel.
    always_comb begin
        req_next.valid      = s_tvalid;
        req_next.cmd        = cmd_t'(s_tuser);
        req_next.byte_index = s_tdata[9:0];
        req_next.byte_value = s_tdata[17:10];
        req_next.dx         = $signed({1'b0, s_tdata[30:24]}) - DxW'(CenterX);
        req_next.dy         = $signed({1'b0, s_tdata[23:18]}) - DyW'(CenterY);
        req_next.radius     = radius_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumSt; i++) begin
                req_reg[i].valid <= 1'b0;
            end
        end else if (adv) begin
            req_reg[0] <= req_next;
            for (int i = 1; i < NumSt; i++) begin
                req_reg[i] <= req_reg[i-1];
            end
        end
    end

    // Squared distance, in whole pixels.
    always_comb begin
        sq_next = SqW'(req_reg[0].dx * req_reg[0].dx) + SqW'(req_reg[0].dy * req_reg[0].dy);
    end

    // Digit-by-digit square root of sq << 20, one digit per stage.
    for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
        localparam logic [RootW-1:0] Bit = RootW'(1) << (32 - 2 * k);
        logic [RootW-1:0] rem_in, res_in, trial;
        logic [RootW-1:0] srem_next, sres_next;
        always_comb begin
            if (k == 0) begin
                rem_in = {2'b0, sq_next, 20'b0};
                res_in = '0;
            end else begin
                rem_in = srem_reg[(k == 0) ? 0 : k-1];
                res_in = sres_reg[(k == 0) ? 0 : k-1];
            end
            trial = res_in + Bit;
            if (rem_in >= trial) begin
                srem_next = rem_in - trial;
                sres_next = (res_in >> 1) + Bit;
            end else begin
                srem_next = rem_in;
                sres_next = res_in >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                srem_reg[k] <= srem_next;
                sres_reg[k] <= sres_next;
            end
        end
    end

    // Restoring divide of (d << 6) by radius, one quotient bit per stage.
    // The top numerator bits seed the remainder; they stay below radius
    // whenever d < radius, the only case that uses the quotient.
    for (genvar j = 0; j < DivN; j++) begin : g_div
        logic [DistW-1:0] d_in;
        logic [7:0]       rem_in;
        logic [DivN-1:0]  q_in;
        logic [22:0]      num;
        logic [8:0]       t;
        logic [7:0]       drem_next;
        logic [DivN-1:0]  dq_next;
        logic [7:0]       rad;
        always_comb begin
            rad = req_reg[StDiv0 + j - 1].radius;
            if (j == 0) begin
                d_in   = sres_reg[SqrtN-1][DistW-1:0];
                rem_in = {1'b0, d_in[16:10]};
                q_in   = '0;
            end else begin
                d_in   = dd_reg[(j == 0) ? 0 : j-1];
                rem_in = drem_reg[(j == 0) ? 0 : j-1];
                q_in   = dq_reg[(j == 0) ? 0 : j-1];
            end
            num = {d_in, 6'b0};
            t   = {rem_in, num[15-j]};
            if (t >= {1'b0, rad}) begin
                drem_next = 8'(t - {1'b0, rad});
                dq_next   = {q_in[DivN-2:0], 1'b1};
            end else begin
                drem_next = t[7:0];
                dq_next   = {q_in[DivN-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                drem_reg[j] <= drem_next;
                dq_reg[j]   <= dq_next;
                dd_reg[j]   <= d_in;
            end
        end
    end

    // Scale: 1 - d/radius inside the radius, else 1.0.
    logic [ThetaW-1:0] theta_next;
    always_comb begin
        if ({1'b0, dd_reg[DivN-1]} < {req_reg[StTheta-1].radius, 10'b0}) begin
            theta_next = 17'h10000 - {1'b0, dq_reg[DivN-1]};
        end else begin
            theta_next = 17'h10000;
        end
    end

    // Scaled offsets, then source coordinates clamped to the frame.
    logic signed [ProdW-1:0] px_next, py_next;
    logic signed [ProdW-17:0] offx, offy;
    logic signed [ProdW-15:0] sxf, syf;
    logic [ColW-1:0] sx_next;
    logic [RowW-1:0] sy_next;
    always_comb begin
        px_next = $signed({1'b0, theta_reg}) * req_reg[StProd-1].dx;
        py_next = $signed({1'b0, theta_reg}) * ProdW'(req_reg[StProd-1].dy);
        offx    = px_reg[ProdW-1:16];
        offy    = py_reg[ProdW-1:16];
        sxf     = (ProdW-14)'(offx) + (ProdW-14)'(CenterX);
        syf     = (ProdW-14)'(offy) + (ProdW-14)'(CenterY);
        if (sxf < 0) begin
            sx_next = '0;
        end else if (sxf > (ProdW-14)'(ImageWidth - 1)) begin
            sx_next = ColW'(ImageWidth - 1);
        end else begin
            sx_next = sxf[ColW-1:0];
        end
        if (syf < 0) begin
            sy_next = '0;
        end else if (syf > (ProdW-14)'(ImageHeight - 1)) begin
            sy_next = RowW'(ImageHeight - 1);
        end else begin
            sy_next = syf[RowW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            theta_reg <= theta_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
        end
    end

    // Frame memory: writes and query reads both happen at the memory stage,
    // so every query sees exactly the writes accepted before it.
    logic [AddrW-1:0] rd_addr;
    req_t             mreq;
    assign mreq    = req_reg[StMem-1];
    assign rd_addr = AddrW'(sy_reg * RowBytes) + AddrW'(sx_reg[ColW-1:3]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (mreq.valid && mreq.cmd == CMD_WRITE
                    && mreq.byte_index < AddrW'(FrameBytes)) begin
                frame_mem[mreq.byte_index] <= mreq.byte_value;
            end
            rd_reg     <= frame_mem[rd_addr];
            sx_mem_reg <= sx_reg;
            sy_mem_reg <= sy_reg;
        end
    end

    // Pick the source pixel, leftmost pixel in bit 7.
    logic [2:0] bit_sel;
    assign bit_sel = 3'd7 - sx_mem_reg[2:0];
    assign m_tdata = {2'b0, sx_mem_reg, sy_mem_reg, rd_reg[bit_sel]};

endmodule

// ----- tb/tb_radial_distortion_remap.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_radial_distortion_remap: self-checking bench for the radial remap block
// Streams frame-byte writes and pixel queries through the block under random
// idling and back-pressure, predicts every query result from a bench-side
// frame copy and fixed-point remap, and compares the results field by field.
// ---------------------------------------------------------------------------
module tb_radial_distortion_remap;
    import rdr_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 60;
    localparam int HoldOffCycles = 400;

    typedef struct {
        cmd_t       cmd;
        logic [9:0] byte_index;
        logic [7:0] byte_value;
        logic [5:0] out_row;
        logic [6:0] out_col;
    } request_t;

    typedef struct {
        logic       pixel;
        logic [5:0] source_row;
        logic [6:0] source_col;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    request_t      pending_requests[$];
    pixel_result_t expected_pixels[$];

    // bench copy of the block state
    logic [7:0] frame_copy[FrameBytes];
    logic [7:0] radius_copy = 8'd50;
    // bytes the stimulus has already written, so no query reads garbage
    bit         byte_written[FrameBytes];

    bit  in_fire = 1'b0;
    bit  quiet = 1'b0;          // suppress random idling on both sides
    bit  hold_off_req = 1'b0;
    bit  hold_off_done = 1'b0;
    bit  failed = 1'b0;
    int  mismatches = 0;
    int  n_writes = 0;
    int  n_queries = 0;
    int  n_results = 0;
    int  idle_cycles = 0;

    always #5 aclk = ~aclk;

    radial_distortion_remap u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // integer square root by the digit-pair method
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // floor(theta * delta / 2^16), rounding toward minus infinity
    function automatic longint scale_offset(longint theta, longint delta);
        longint p;
        p = theta * delta;
        if (p >= 0) return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    function automatic longint clamp(longint v, longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // source pixel of an output pixel for a given radius
    task automatic remap_source(input logic [5:0] row, input logic [6:0] col,
                                input logic [7:0] rad, output int sy, output int sx);
        longint dx;
        longint dy;
        longint unsigned distance;
        longint theta;
        dx = longint'(col) - CenterX;
        dy = longint'(row) - CenterY;
        distance = int_sqrt(longint'(dx * dx + dy * dy) << 20);
        theta = 64'h10000;
        if (distance < (longint'(rad) << 10))
            theta = 64'h10000 - longint'((distance * 64) / rad);
        sx = int'(clamp(CenterX + scale_offset(theta, dx), ImageWidth - 1));
        sy = int'(clamp(CenterY + scale_offset(theta, dy), ImageHeight - 1));
    endtask

    // queue a query; write its source byte first if the frame lacks it
    task automatic add_query(input logic [5:0] row, input logic [6:0] col);
        request_t r;
        int sy;
        int sx;
        int addr;
        remap_source(row, col, radius_copy, sy, sx);
        addr = sy * RowBytes + sx / 8;
        if (!byte_written[addr]) begin
            r.cmd = CMD_WRITE;
            r.byte_index = addr[9:0];
            r.byte_value = 8'($urandom);
            r.out_row = 6'($urandom);
            r.out_col = 7'($urandom);
            byte_written[addr] = 1'b1;
            pending_requests.push_back(r);
        end
        r.cmd = CMD_QUERY;
        r.byte_index = 10'($urandom);
        r.byte_value = 8'($urandom);
        r.out_row = row;
        r.out_col = col;
        pending_requests.push_back(r);
    endtask

    task automatic add_write(input logic [9:0] idx, input logic [7:0] val);
        request_t r;
        r.cmd = CMD_WRITE;
        r.byte_index = idx;
        r.byte_value = val;
        r.out_row = 6'($urandom);
        r.out_col = 7'($urandom);
        if (idx < FrameBytes) byte_written[idx] = 1'b1;
        pending_requests.push_back(r);
    endtask

    // mostly in-frame writes and queries; some out-of-range noise
    task automatic add_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 35) begin
                if ($urandom_range(19) == 0) add_write(10'($urandom), 8'($urandom));
                else add_write(10'($urandom_range(FrameBytes - 1)), 8'($urandom));
            end else if ($urandom_range(9) == 0) begin
                add_query(6'($urandom), 7'($urandom));
            end else begin
                add_query(6'($urandom_range(ImageHeight - 1)),
                          7'($urandom_range(ImageWidth - 1)));
            end
        end
    endtask

    // input side: predict at acceptance, update the bench frame copy
    always @(posedge aclk) begin
        pixel_result_t e;
        int sy;
        int sx;
        logic [7:0] b;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            if (cmd_t'(s_tuser) == CMD_WRITE) begin
                n_writes++;
                if (s_tdata[9:0] < FrameBytes) frame_copy[s_tdata[9:0]] = s_tdata[17:10];
            end else begin
                n_queries++;
                remap_source(s_tdata[23:18], s_tdata[30:24], radius_copy, sy, sx);
                b = frame_copy[sy * RowBytes + sx / 8];
                e.pixel = b[7 - (sx % 8)];
                e.source_row = sy[5:0];
                e.source_col = sx[6:0];
                expected_pixels.push_back(e);
            end
        end
    end

    // driver: advance to the next request once the current one is taken
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_requests.size() > 0 && (quiet || $urandom_range(99) >= 11)) begin
                r = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= r.cmd;
                s_tdata <= {1'b0, r.out_col, r.out_row, r.byte_value, r.byte_index};
            end else begin
                s_tvalid <= 1'b0;
                s_tdata <= $urandom;
                s_tuser <= 1'($urandom);
            end
        end
    end

    // receiver: random stalls plus one long hold-off counted here
    always @(negedge aclk) begin
        int held;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            if (held < HoldOffCycles) begin
                m_tready <= 1'b0;
                held++;
            end else begin
                hold_off_done = 1'b1;
                m_tready <= 1'b1;
            end
        end else begin
            held = 0;
            m_tready <= quiet || ($urandom_range(99) >= 11);
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        pixel_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_pixels.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", m_tdata);
            end else begin
                e = expected_pixels.pop_front();
                if (m_tdata[0] !== e.pixel || m_tdata[6:1] !== e.source_row ||
                    m_tdata[13:7] !== e.source_col) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: pixel/row/col exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 e.pixel, e.source_row, e.source_col,
                                 m_tdata[0], m_tdata[6:1], m_tdata[13:7]);
                end
            end
        end
    end

    // watchdog: end the run after too many cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("ERROR: watchdog expired with %0d results outstanding",
                     expected_pixels.size());
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // wait until the block has drained, then let its pipeline settle
    task automatic drain();
        while (pending_requests.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [7:0] rad);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= rad;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        radius_copy = rad;
    endtask

    initial begin
        logic [7:0] radii[5];
        int p;
        radii[0] = 8'd1;
        radii[1] = 8'd255;
        radii[2] = 8'd0;
        radii[3] = 8'($urandom_range(2, 254));
        radii[4] = 8'($urandom_range(20, 60));
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes at reset radius, out-of-range writes, corners
        add_write(10'd0, 8'hFF);
        add_write(10'd599, 8'h80);
        add_write(10'd600, 8'hAA);
        add_write(10'd1023, 8'h55);
        add_query(6'd30, 7'd40);
        add_query(6'd0, 7'd0);
        add_query(6'd59, 7'd79);
        add_query(6'd0, 7'd79);
        add_query(6'd59, 7'd0);
        add_query(6'd63, 7'd127);
        add_query(6'd0, 7'd127);
        add_query(6'd63, 7'd0);
        add_query(6'd30, 7'd90);
        add_query(6'd55, 7'd40);
        add_random(230);
        hold_off_req = 1'b1;     // long receiver stall fills the pipeline
        drain();

        for (p = 0; p < 5; p++) begin
            write_radius(radii[p]);
            quiet = (p == 1);    // one phase runs at full rate
            add_query(6'd30, 7'd41);
            add_query(6'd0, 7'd0);
            add_query(6'd63, 7'd127);
            add_random(240);
            drain();
        end

        $display("tb: %0d writes, %0d queries, %0d results over six radius settings",
                 n_writes, n_queries, n_results);
        $display("tb: %0d mismatches, one %0d-cycle receiver hold-off",
                 mismatches, HoldOffCycles);
        if (!failed && expected_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
